FILE: sv/tet_pkg.sv
// tet_pkg: shared types and constants for the timer expiry table
// used by every module of the block; no dependencies

package tet_pkg;

  localparam int unsigned TIMER_SLOTS = 16;
  localparam int unsigned SLOT_IDX_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned SLOT_CNT_W  = $clog2(TIMER_SLOTS + 1);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [16:0] WAIT_CAP_USEC = 17'd100000;

  typedef enum logic [1:0] {
    ST_SCHEDULED   = 2'd0,
    ST_FIRED       = 2'd1,
    ST_NOTHING_DUE = 2'd2,
    ST_FULL        = 2'd3
  } status_e;

  typedef enum logic {
    REQ_SCHEDULE = 1'b0,
    REQ_TICK     = 1'b1
  } req_kind_e;

  // classified request: time holds the deadline for a schedule, now for a tick
  typedef struct packed {
    req_kind_e   kind;
    logic [63:0] time_usec;
    logic [31:0] tag;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] fired_tag;
    logic [16:0] wait_usec;
  } res_t;

  typedef struct packed {
    logic [63:0] deadline;
    logic [31:0] tag;
    logic [31:0] order;
  } slot_t;

endpackage

FILE: sv/tet_front.sv
// tet_front: accepts requests, classifies them and holds them in a short queue
// depends on tet_pkg

module tet_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full,
  input  logic               req_type_i,
  input  logic [63:0]        deadline_usec_i,
  input  logic [31:0]        context_tag_i,
  input  logic [63:0]        now_usec_i,
  output logic               req_valid_o,
  output tet_pkg::req_t      req_o,
  input  logic               req_take_i
);

  tet_pkg::req_t                        fifo_q [tet_pkg::QUEUE_DEPTH];
  logic [tet_pkg::QUEUE_PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [tet_pkg::QUEUE_PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [tet_pkg::QUEUE_CNT_W-1:0]      cnt_q, cnt_d;
  tet_pkg::req_t                        req_in;
  logic                                 do_push, do_pop;

  always_comb begin
    req_in.kind      = tet_pkg::req_kind_e'(req_type_i);
    req_in.time_usec = (req_type_i == tet_pkg::REQ_TICK) ? now_usec_i : deadline_usec_i;
    req_in.tag       = context_tag_i;
  end

  assign full        = (cnt_q == tet_pkg::QUEUE_CNT_W'(tet_pkg::QUEUE_DEPTH));
  assign req_valid_o = (cnt_q != '0);
  assign req_o       = fifo_q[rd_ptr_q];
  assign do_push     = push_i && !full;
  assign do_pop      = req_take_i && req_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == tet_pkg::QUEUE_PTR_W'(tet_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == tet_pkg::QUEUE_PTR_W'(tet_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_ptr_q] <= req_in;
    end
  end

endmodule

FILE: sv/tet_resq.sv
// tet_resq: short result queue between the scan engine and the output ports
// depends on tet_pkg

module tet_resq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_push_i,
  input  tet_pkg::res_t      res_i,
  output logic               res_space_o,
  output logic               empty,
  input  logic               pop,
  output tet_pkg::res_t      head_o
);

  tet_pkg::res_t                        fifo_q [tet_pkg::QUEUE_DEPTH];
  logic [tet_pkg::QUEUE_PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [tet_pkg::QUEUE_PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [tet_pkg::QUEUE_CNT_W-1:0]      cnt_q, cnt_d;
  logic                                 do_push, do_pop;

  assign res_space_o = (cnt_q != tet_pkg::QUEUE_CNT_W'(tet_pkg::QUEUE_DEPTH));
  assign empty       = (cnt_q == '0);
  assign head_o      = fifo_q[rd_ptr_q];
  assign do_push     = res_push_i && res_space_o;
  assign do_pop      = pop && !empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == tet_pkg::QUEUE_PTR_W'(tet_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == tet_pkg::QUEUE_PTR_W'(tet_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

FILE: sv/tet_back.sv
// tet_back: slot table and scan engine that carries out schedule and tick requests
// depends on tet_pkg

module tet_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  tet_pkg::req_t      req_i,
  output logic               req_take_o,
  input  logic               res_space_i,
  output logic               res_push_o,
  output tet_pkg::res_t      res_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCHED  = 2'd1;
  localparam logic [1:0] S_TICK   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  localparam int unsigned IDXW = tet_pkg::SLOT_IDX_W;
  localparam int unsigned CNTW = tet_pkg::SLOT_CNT_W;

  // slot table memory, registered read
  tet_pkg::slot_t             slot_mem [tet_pkg::TIMER_SLOTS];
  tet_pkg::slot_t             rd_data_q;
  tet_pkg::slot_t             wr_data;
  logic                       mem_we;

  logic [1:0]                 state_q, state_d;
  tet_pkg::req_t              req_q, req_d;
  logic [CNTW-1:0]            idx_q, idx_d;
  logic [IDXW-1:0]            cur_idx;
  logic [tet_pkg::TIMER_SLOTS-1:0] valid_q, valid_d;
  logic [31:0]                order_cnt_q, order_cnt_d;
  logic                       rd_vld_q, rd_vld_d;
  logic [IDXW-1:0]            rd_idx_q;
  logic                       have_pick_q, have_pick_d;
  logic [IDXW-1:0]            pick_idx_q, pick_idx_d;
  logic [31:0]                best_age_q, best_age_d;
  logic [31:0]                best_tag_q, best_tag_d;
  logic [16:0]                wait_q, wait_d;

  logic                       issue;
  logic                       due;
  logic [31:0]                age;
  logic [63:0]                diff;

  assign cur_idx = idx_q[IDXW-1:0];
  assign issue   = (state_q == S_TICK) && (idx_q < CNTW'(tet_pkg::TIMER_SLOTS));
  assign due     = (rd_data_q.deadline <= req_q.time_usec);
  // age wraps modulo 2^32, largest is oldest
  assign age     = order_cnt_q - rd_data_q.order;
  assign diff    = rd_data_q.deadline - req_q.time_usec;

  always_comb begin
    wr_data.deadline = req_q.time_usec;
    wr_data.tag      = req_q.tag;
    wr_data.order    = order_cnt_q;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    idx_d       = idx_q;
    valid_d     = valid_q;
    order_cnt_d = order_cnt_q;
    rd_vld_d    = issue;
    have_pick_d = have_pick_q;
    pick_idx_d  = pick_idx_q;
    best_age_d  = best_age_q;
    best_tag_d  = best_tag_q;
    wait_d      = wait_q;
    mem_we      = 1'b0;
    req_take_o  = 1'b0;
    res_push_o  = 1'b0;
    res_o.status    = tet_pkg::ST_SCHEDULED;
    res_o.fired_tag = '0;
    res_o.wait_usec = '0;

    case (state_q)
      S_IDLE: begin
        // only start when the result queue has room for the answer
        if (req_valid_i && res_space_i) begin
          req_take_o  = 1'b1;
          req_d       = req_i;
          idx_d       = '0;
          have_pick_d = 1'b0;
          best_age_d  = '0;
          wait_d      = tet_pkg::WAIT_CAP_USEC;
          state_d     = (req_i.kind == tet_pkg::REQ_TICK) ? S_TICK : S_SCHED;
        end
      end
      S_SCHED: begin
        // look for the lowest free slot, one slot a cycle
        if (!valid_q[cur_idx]) begin
          mem_we             = 1'b1;
          valid_d[cur_idx]   = 1'b1;
          order_cnt_d        = order_cnt_q + 32'd1;
          res_push_o         = 1'b1;
          res_o.status       = tet_pkg::ST_SCHEDULED;
          state_d            = S_IDLE;
        end else if (idx_q == CNTW'(tet_pkg::TIMER_SLOTS - 1)) begin
          res_push_o   = 1'b1;
          res_o.status = tet_pkg::ST_FULL;
          state_d      = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_TICK: begin
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end else begin
          state_d = S_FINISH;
        end
        if (rd_vld_q && valid_q[rd_idx_q]) begin
          if (due) begin
            if (!have_pick_q || (age > best_age_q)) begin
              have_pick_d = 1'b1;
              pick_idx_d  = rd_idx_q;
              best_age_d  = age;
              best_tag_d  = rd_data_q.tag;
            end
          end else if (diff < 64'(wait_q)) begin
            wait_d = diff[16:0];
          end
        end
      end
      S_FINISH: begin
        res_push_o = 1'b1;
        if (have_pick_q) begin
          valid_d[pick_idx_q] = 1'b0;
          res_o.status        = tet_pkg::ST_FIRED;
          res_o.fired_tag     = best_tag_q;
        end else begin
          res_o.status    = tet_pkg::ST_NOTHING_DUE;
          res_o.wait_usec = wait_q;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      order_cnt_q <= '0;
      rd_vld_q    <= 1'b0;
      have_pick_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      order_cnt_q <= order_cnt_d;
      rd_vld_q    <= rd_vld_d;
      have_pick_q <= have_pick_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    rd_idx_q   <= cur_idx;
    pick_idx_q <= pick_idx_d;
    best_age_q <= best_age_d;
    best_tag_q <= best_tag_d;
    wait_q     <= wait_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[cur_idx] <= wr_data;
    end
    rd_data_q <= slot_mem[cur_idx];
  end

endmodule

FILE: sv/timer_expiry_table.sv
// timer_expiry_table: request queue, slot scan engine and result queue.
// a schedule searches for a free slot, one slot a cycle; a tick scans every slot,
// reading one slot a cycle from the slot memory.
// the scan engine takes one request at a time and takes the next only when back in
// idle with room in the result queue; short queues on both sides.
// reset: asynchronous, clears all slots, the order counter and both queues.

module timer_expiry_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        req_type_i,
  input  logic [63:0] deadline_usec_i,
  input  logic [31:0] context_tag_i,
  input  logic [63:0] now_usec_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [31:0] fired_tag_o,
  output logic [16:0] wait_usec_o
);

  logic          req_valid;
  logic          req_take;
  tet_pkg::req_t req;
  logic          res_space;
  logic          res_push;
  tet_pkg::res_t res;
  tet_pkg::res_t head;

  tet_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full            (full),
    .req_type_i      (req_type_i),
    .deadline_usec_i (deadline_usec_i),
    .context_tag_i   (context_tag_i),
    .now_usec_i      (now_usec_i),
    .req_valid_o     (req_valid),
    .req_o           (req),
    .req_take_i      (req_take)
  );

  tet_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_take_o  (req_take),
    .res_space_i (res_space),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  tet_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_push_i  (res_push),
    .res_i       (res),
    .res_space_o (res_space),
    .empty       (empty),
    .pop         (pop),
    .head_o      (head)
  );

  assign status_o    = head.status;
  assign fired_tag_o = head.fired_tag;
  assign wait_usec_o = head.wait_usec;

endmodule
